// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the escape decoder.
// No dependencies; simulation gets the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bed assertion failed");
// Condition must never be true outside reset.
`define BED_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bed forbidden condition seen");
`else
`define BED_ASSERT(lbl, clk, rstn, prop)
`define BED_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/bed_pkg.sv =====
// Package of the backslash escape decoder: byte codes, escape phase type,
// decoded burst struct and the escape character table. No dependencies.
package bed_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxOut  = 4;
  localparam int unsigned CntW    = $clog2(MaxOut + 1);
  localparam int unsigned IdxW    = $clog2(MaxOut);

  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_DQ    = 8'h22;
  localparam logic [ByteW-1:0] CH_SQ    = 8'h27;
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5C;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_THREE = 8'h33;
  localparam logic [ByteW-1:0] CH_QMARK = 8'h3F;
  localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,  // no escape pending
    PH_BSL   = 2'd1,  // after backslash
    PH_ZERO  = 2'd2,  // after backslash 0
    PH_ZERO3 = 2'd3   // after backslash 0 3
  } bed_phase_t;

  typedef struct packed {
    logic [CntW-1:0]              cnt;    // number of result bytes
    logic [MaxOut-1:0][ByteW-1:0] bytes;  // result bytes, index 0 first
    logic                         last;   // final byte is the terminator
  } bed_burst_t;

  // Decoded value of a known escape character, zero when unknown.
  function automatic logic [ByteW-1:0] map_escape(input logic [ByteW-1:0] ch);
    logic [ByteW-1:0] res;
    case (ch)
      8'h61:   res = 8'h07;    // a
      8'h62:   res = 8'h08;    // b
      8'h66:   res = 8'h0C;    // f
      8'h6E:   res = 8'h0A;    // n
      8'h72:   res = 8'h0D;    // r
      8'h74:   res = 8'h09;    // t
      8'h76:   res = 8'h0B;    // v
      CH_BSL:  res = CH_BSL;
      CH_SQ:   res = CH_SQ;
      CH_DQ:   res = CH_DQ;
      CH_QMARK: res = CH_QMARK;
      8'h65:   res = CH_ESC;   // e
      default: res = CH_NUL;
    endcase
    return res;
  endfunction

endpackage

// ===== src/bed_decode.sv =====
// Combinational decode of one byte against the escape/quote state.
// Depends on bed_pkg.
module bed_decode
  import bed_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  input  logic             quotes_i,
  input  bed_phase_t       phase_i,
  output bed_burst_t       burst_o,
  output logic             quotes_nxt_o,
  output bed_phase_t       phase_nxt_o
);

  logic [ByteW-1:0] mapped;
  logic             pl_emit;
  logic             pl_last;
  logic             pl_quotes;
  bed_phase_t       pl_phase;
  logic [CntW-1:0]  pfx;       // held bytes flushed before the plain byte
  logic             use_plain;

  assign mapped = map_escape(byte_i);

  // Ordinary handling of the byte with no escape pending.
  always_comb begin
    pl_emit   = 1'b0;
    pl_last   = 1'b0;
    pl_quotes = quotes_i;
    pl_phase  = PH_IDLE;
    if (byte_i == CH_NUL) begin
      pl_emit   = 1'b1;
      pl_last   = 1'b1;
      pl_quotes = 1'b0;
    end else if (byte_i == CH_DQ) begin
      pl_quotes = ~quotes_i;
    end else if (byte_i == CH_BSL && !quotes_i) begin
      pl_phase = PH_BSL;
    end else begin
      pl_emit = 1'b1;
    end
  end

  always_comb begin
    pfx          = '0;
    use_plain    = 1'b0;
    quotes_nxt_o = quotes_i;
    phase_nxt_o  = PH_IDLE;
    burst_o.bytes = {CH_NUL, CH_THREE, CH_ZERO, CH_BSL};
    burst_o.cnt   = '0;
    burst_o.last  = 1'b0;
    case (phase_i)
      PH_BSL: begin
        if (byte_i == CH_NUL) begin
          use_plain = 1'b1;
        end else if (byte_i == CH_ZERO) begin
          phase_nxt_o = PH_ZERO;
        end else if (mapped != CH_NUL) begin
          burst_o.bytes[0] = mapped;
          burst_o.cnt      = CntW'(1);
        end else begin
          pfx       = CntW'(1);
          use_plain = 1'b1;
        end
      end
      PH_ZERO: begin
        if (byte_i == CH_THREE) begin
          phase_nxt_o = PH_ZERO3;
        end else begin
          pfx       = CntW'(2);
          use_plain = 1'b1;
        end
      end
      PH_ZERO3: begin
        if (byte_i == CH_THREE) begin
          burst_o.bytes[0] = CH_ESC;
          burst_o.cnt      = CntW'(1);
        end else begin
          pfx       = CntW'(3);
          use_plain = 1'b1;
        end
      end
      default: begin
        use_plain = 1'b1;
      end
    endcase

    if (use_plain) begin
      quotes_nxt_o = pl_quotes;
      phase_nxt_o  = pl_phase;
      burst_o.cnt  = pfx + CntW'(pl_emit);
      burst_o.last = pl_last;
      burst_o.bytes[pfx[IdxW-1:0]] = byte_i;
    end
  end

endmodule

// ===== src/bed_emit.sv =====
// Result buffer: holds one decoded burst and drains it one byte per transaction.
// Depends on bed_pkg.
module bed_emit
  import bed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  bed_burst_t       burst_i,
  output logic             free_o,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,
  output logic             out_tlast
);

  logic [MaxOut-1:0][ByteW-1:0] bytes_r;
  logic                         last_r;
  logic [CntW-1:0]              rem_r, rem_nxt;
  logic [IdxW-1:0]              idx_r, idx_nxt;
  logic                         xfer;

  assign out_tvalid = (rem_r != '0);
  assign xfer       = out_tvalid && out_tready;
  assign free_o     = (rem_r == '0) || (rem_r == CntW'(1) && out_tready);
  assign out_tdata  = bytes_r[idx_r];
  assign out_tlast  = last_r && (rem_r == CntW'(1));

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load_i) begin
      rem_nxt = burst_i.cnt;
      idx_nxt = '0;
    end else if (xfer) begin
      rem_nxt = rem_r - CntW'(1);
      idx_nxt = idx_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      bytes_r <= burst_i.bytes;
      last_r  <= burst_i.last;
    end
  end

endmodule

// ===== src/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder: input register, state and result buffer.
// Depends on bed_pkg, bed_decode, bed_emit and assert_macros.svh.
//
// Usage:
//   Input channel in_*: one string byte per transaction in in_tdata. A zero byte
//   ends the string; it comes out as the final result with out_tlast high and it
//   clears the quote and escape state. Double quotes toggle quoted mode and are
//   dropped; outside quotes backslash escapes are decoded (C letters, \e, \033).
//   Output channel out_*: one decoded byte per transaction, out_tlast marks the
//   terminator. One input byte gives zero to four output bytes.
//   Path: a byte accepted on in_* is registered in the input register, decoded
//   and loaded into the result buffer once it is free; out_* takes its results there.
//   Throughput (out_tready high): one byte per cycle while each byte gives at most
//   one result. A byte that flushes a broken escape gives up to four results,
//   drained one per cycle from the buffer; in_tready drops once a byte waits behind.
//   Stall: with out_tready low the result buffer holds, the input register
//   fills, and then in_tready falls. Nothing is lost or repeated.
//   Reset: rst_n low (synchronous) empties both registers, leaves quoted mode
//   and drops any pending escape.
`include "assert_macros.svh"

module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,    // [7:0] in_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,   // [7:0] out_byte
  output logic             out_tlast    // last
);

  // Input register stage.
  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  // Quote / escape state, updated when the registered byte is decoded.
  logic             quotes_r, quotes_nxt;
  bed_phase_t       phase_r, phase_nxt;

  bed_burst_t dec_burst;
  logic       buf_free;
  logic       s1_adv;     // registered byte moves into the result buffer
  logic       in_xfer;

  assign s1_adv    = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || buf_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  bed_decode u_decode (
    .byte_i       (s1_byte_r),
    .quotes_i     (quotes_r),
    .phase_i      (phase_r),
    .burst_o      (dec_burst),
    .quotes_nxt_o (quotes_nxt),
    .phase_nxt_o  (phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      quotes_r   <= 1'b0;
      phase_r    <= PH_IDLE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        quotes_r <= quotes_nxt;
        phase_r  <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
    end
  end

  bed_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (s1_adv),
    .burst_i    (dec_burst),
    .free_o     (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A terminator leaves no quote or escape state behind.
  `BED_ASSERT(a_term_clears, clk, rst_n,
    (s1_adv && s1_byte_r == CH_NUL) |=> (!quotes_r && phase_r == PH_IDLE))
  // The terminator result always carries a zero byte.
  `BED_ASSERT_NEVER(a_last_nonzero, clk, rst_n,
    out_tvalid && out_tlast && out_tdata != CH_NUL)
  // A decoded byte that yields results shows them on the next cycle.
  `BED_ASSERT(a_burst_shown, clk, rst_n,
    (s1_adv && dec_burst.cnt != '0) |=> out_tvalid)
  // Quoted mode never coexists with a pending escape.
  `BED_ASSERT_NEVER(a_quote_escape, clk, rst_n,
    quotes_r && phase_r != PH_IDLE)

endmodule
